// ===== hdl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers shared by the deframer rtl
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// checked on every clock edge outside reset
`define SFD_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked on every clock edge, reset included
`define SFD_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SFD_ASSERT(name, clk, rst_n, prop, msg)
`define SFD_ASSERT_ALWAYS(name, clk, prop, msg)
`endif

`endif

// ===== hdl/sfd_pkg.sv =====
// ---------------------------------------------------------------------------
// sfd_pkg
// shared constants, codes and the crc-32 byte update of the frame decoder
// ---------------------------------------------------------------------------
package sfd_pkg;

  localparam int unsigned MAX_PAYLOAD = 1024;

  localparam int unsigned LIMIT_W  = 11;
  localparam int unsigned POS_W    = 12;
  localparam int unsigned HEAD_LEN = 12;
  localparam int unsigned CRC_FROM = 3;
  localparam int unsigned LEN_OFFSET = 10;

  localparam logic [LIMIT_W-1:0] LIMIT_RST = 11'd1024;

  localparam logic [7:0] START_BYTE = 8'h05;
  localparam logic [7:0] MARK1_BYTE = 8'h53;
  localparam logic [7:0] MARK2_BYTE = 8'h46;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;

  typedef enum logic [1:0] {
    CMD_FEED  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_ABORT = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_NONE    = 3'd0,
    ST_GOOD    = 3'd1,
    ST_BAD_LEN = 3'd2,
    ST_BAD_CRC = 3'd3,
    ST_READ    = 3'd4
  } status_e;

  // reflected crc-32, one byte
  function automatic logic [31:0] crc32_byte(logic [31:0] c, logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

endpackage

// ===== hdl/sfd_in_if.sv =====
// ---------------------------------------------------------------------------
// sfd_in_if
// command channel of the frame decoder
// ---------------------------------------------------------------------------
interface sfd_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] data_byte;
  logic [9:0] read_index;

  modport source (output valid, cmd, data_byte, read_index, input ready);
  modport sink   (input valid, cmd, data_byte, read_index, output ready);
endinterface

// ===== hdl/sfd_out_if.sv =====
// ---------------------------------------------------------------------------
// sfd_out_if
// result channel of the frame decoder
// ---------------------------------------------------------------------------
interface sfd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [7:0]  frame_type;
  logic [31:0] session_id;
  logic [15:0] sequence_number;
  logic [10:0] payload_length;
  logic [7:0]  read_data;
  logic        busy_res;
  logic [15:0] crc_error_count;
  logic [15:0] length_error_count;

  modport source (output valid, status, frame_type, session_id, sequence_number,
                  payload_length, read_data, busy_res, crc_error_count,
                  length_error_count, input ready);
  modport sink   (input valid, status, frame_type, session_id, sequence_number,
                  payload_length, read_data, busy_res, crc_error_count,
                  length_error_count, output ready);
endinterface

// ===== hdl/sfd_ram.sv =====
// ---------------------------------------------------------------------------
// sfd_ram
// generic single-write, single-read ram with registered read data
// ---------------------------------------------------------------------------
module sfd_ram #(
  parameter  int unsigned Width = 8,
  parameter  int unsigned Depth = 1024,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/serial_frame_decoder_unit.sv =====
// ---------------------------------------------------------------------------
// serial_frame_decoder_unit
// byte-serial deframer: start/marker hunt, 12-byte header, payload buffer,
// crc-32 check, header report and payload read-back
// ---------------------------------------------------------------------------
//  channel  dir  handshake      word contents
//  in_i     in   valid/ready    cmd, data_byte, read_index
//  out_o    out  valid/ready    status, last good header, read_data, busy,
//                               crc and length error counters
//  cfg      in   cfg_we_i only  payload_limit (11 bits)
//
//  one word per cycle while the output is not stalled; each accepted word gives one registered result word
//  the result sits in an output register; a new word is taken in the same
//  cycle the pending result is taken, so a stalled output stalls the input
//  the payload ram read data is registered, in step with the output register
//  reset (async, active low) clears the parser, counters and last good frame;
//  the payload ram is not cleared, reads are gated by the good-frame rule
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module serial_frame_decoder_unit #(
  parameter int unsigned MaxPayload = sfd_pkg::MAX_PAYLOAD
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [sfd_pkg::LIMIT_W-1:0] cfg_wdata_i,
  sfd_in_if.sink                      in_i,
  sfd_out_if.source                   out_o
);

  import sfd_pkg::*;

  localparam int unsigned AddrW = $clog2(MaxPayload);
  localparam logic [16:0] MaxW  = 17'(MaxPayload);

  // configuration
  logic [LIMIT_W-1:0] limit_q, limit_d, eff_limit;

  // parser state
  logic [POS_W-1:0]   pos_q, pos_d;
  logic [LIMIT_W-1:0] plen_q, plen_d;
  logic [31:0]        crc_q, crc_d;
  logic [31:0]        rxcrc_q, rxcrc_d;
  logic [7:0]         hdr_q [CRC_FROM:HEAD_LEN-1];

  // counters and last good frame
  logic [15:0]        cnt_crc_q, cnt_crc_d;
  logic [15:0]        cnt_len_q, cnt_len_d;
  logic               gv_q, gv_d;
  logic [7:0]         gtype_q, gtype_d;
  logic [31:0]        gsess_q, gsess_d;
  logic [15:0]        gseq_q, gseq_d;
  logic [LIMIT_W-1:0] glen_q, glen_d;

  // output register
  logic               ovalid_q, ovalid_d;
  status_e            status_q, status_d;
  logic               hit_q, hit_d;

  // datapath helpers
  logic               in_acc, acc_clear, hdr_we;
  logic [7:0]         b;
  logic [POS_W-1:0]   off, coff;
  logic               in_payload;
  logic [31:0]        crc_upd, rx_next;
  logic [15:0]        len16;
  logic [7:0]         want;
  logic               ram_we, ram_re;
  logic [7:0]         ram_rdata;

  assign in_i.ready = !ovalid_q || out_o.ready;
  assign in_acc     = in_i.valid && in_i.ready;
  assign acc_clear  = in_acc && (in_i.cmd == CMD_CLEAR);
  assign b          = in_i.data_byte;

  // limit in force is the smaller of the register and the buffer size
  assign eff_limit = ({6'd0, limit_q} > MaxW) ? MaxW[LIMIT_W-1:0] : limit_q;

  assign off        = pos_q - POS_W'(HEAD_LEN);
  assign coff       = off - POS_W'(plen_q);
  assign in_payload = off < POS_W'(plen_q);
  assign crc_upd    = crc32_byte(crc_q, b);
  assign rx_next    = {b, rxcrc_q[31:8]};
  assign len16      = {b, hdr_q[LEN_OFFSET]};
  assign want       = (pos_q == POS_W'(1)) ? MARK1_BYTE : MARK2_BYTE;

  // header bytes are taken in the type..length span
  assign hdr_we = in_acc && (in_i.cmd == CMD_FEED) &&
                  (pos_q >= POS_W'(CRC_FROM)) && (pos_q < POS_W'(HEAD_LEN));

  always_comb begin
    limit_d   = cfg_we_i ? cfg_wdata_i : limit_q;
    pos_d     = pos_q;
    plen_d    = plen_q;
    crc_d     = crc_q;
    rxcrc_d   = rxcrc_q;
    cnt_crc_d = cnt_crc_q;
    cnt_len_d = cnt_len_q;
    gv_d      = gv_q;
    gtype_d   = gtype_q;
    gsess_d   = gsess_q;
    gseq_d    = gseq_q;
    glen_d    = glen_q;
    status_d  = status_q;
    hit_d     = hit_q;
    ovalid_d  = ovalid_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;

    if (in_acc) begin
      ovalid_d = 1'b1;
      status_d = ST_NONE;
      hit_d    = 1'b0;
      unique case (in_i.cmd)
        CMD_FEED: begin
          priority if (pos_q == '0) begin
            // hunting for the start byte
            if (b == START_BYTE) begin
              pos_d = POS_W'(1);
              gv_d  = 1'b0;
            end
          end else if (pos_q < POS_W'(CRC_FROM)) begin
            // marker bytes; a mismatch restarts the hunt on this byte
            if (b != want) begin
              pos_d = '0;
              if (b == START_BYTE) begin
                pos_d = POS_W'(1);
                gv_d  = 1'b0;
              end
            end else begin
              pos_d = pos_q + POS_W'(1);
              if (pos_q == POS_W'(CRC_FROM - 1)) begin
                crc_d = '1;
              end
            end
          end else if (pos_q < POS_W'(HEAD_LEN)) begin
            crc_d = crc_upd;
            pos_d = pos_q + POS_W'(1);
            if (pos_q == POS_W'(HEAD_LEN - 1)) begin
              if (len16 > {5'd0, eff_limit}) begin
                cnt_len_d = cnt_len_q + 16'd1;
                pos_d     = '0;
                status_d  = ST_BAD_LEN;
              end else begin
                plen_d = len16[LIMIT_W-1:0];
              end
            end
          end else if (in_payload) begin
            ram_we = 1'b1;
            crc_d  = crc_upd;
            pos_d  = pos_q + POS_W'(1);
          end else begin
            // trailing crc, little endian
            rxcrc_d = rx_next;
            pos_d   = pos_q + POS_W'(1);
            if (coff[1:0] == 2'd3) begin
              pos_d = '0;
              if (rx_next != ~crc_q) begin
                cnt_crc_d = cnt_crc_q + 16'd1;
                status_d  = ST_BAD_CRC;
              end else begin
                gtype_d  = hdr_q[3];
                gsess_d  = {hdr_q[7], hdr_q[6], hdr_q[5], hdr_q[4]};
                gseq_d   = {hdr_q[9], hdr_q[8]};
                glen_d   = plen_q;
                gv_d     = 1'b1;
                status_d = ST_GOOD;
              end
            end
          end
        end
        CMD_READ: begin
          status_d = ST_READ;
          ram_re   = 1'b1;
          hit_d    = gv_q && ({1'b0, in_i.read_index} < glen_q);
        end
        CMD_ABORT: begin
          pos_d = '0;
        end
        CMD_CLEAR: begin
          pos_d     = '0;
          crc_d     = '1;
          cnt_crc_d = '0;
          cnt_len_d = '0;
          gv_d      = 1'b0;
          gtype_d   = '0;
          gsess_d   = '0;
          gseq_d    = '0;
          glen_d    = '0;
        end
        default: ;
      endcase
    end else if (out_o.ready) begin
      ovalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q   <= LIMIT_RST;
      pos_q     <= '0;
      cnt_crc_q <= '0;
      cnt_len_q <= '0;
      gv_q      <= 1'b0;
      gtype_q   <= '0;
      gsess_q   <= '0;
      gseq_q    <= '0;
      glen_q    <= '0;
      ovalid_q  <= 1'b0;
      status_q  <= ST_NONE;
      hit_q     <= 1'b0;
    end else begin
      limit_q   <= limit_d;
      pos_q     <= pos_d;
      cnt_crc_q <= cnt_crc_d;
      cnt_len_q <= cnt_len_d;
      gv_q      <= gv_d;
      gtype_q   <= gtype_d;
      gsess_q   <= gsess_d;
      gseq_q    <= gseq_d;
      glen_q    <= glen_d;
      ovalid_q  <= ovalid_d;
      status_q  <= status_d;
      hit_q     <= hit_d;
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk_i) begin
    plen_q  <= plen_d;
    crc_q   <= crc_d;
    rxcrc_q <= rxcrc_d;
    for (int i = CRC_FROM; i < HEAD_LEN; i++) begin
      if (hdr_we && (pos_q == POS_W'(i))) begin
        hdr_q[i] <= b;
      end
    end
  end

  // payload buffer
  sfd_ram #(
    .Width (8),
    .Depth (MaxPayload)
  ) u_payload_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AddrW'(off)),
    .wdata_i (b),
    .re_i    (ram_re),
    .raddr_i (AddrW'(in_i.read_index)),
    .rdata_o (ram_rdata)
  );

  // state between accepts is exactly the state after the pending word
  assign out_o.valid              = ovalid_q;
  assign out_o.status             = status_q;
  assign out_o.frame_type         = gtype_q;
  assign out_o.session_id         = gsess_q;
  assign out_o.sequence_number    = gseq_q;
  assign out_o.payload_length     = glen_q;
  assign out_o.read_data          = hit_q ? ram_rdata : 8'd0;
  assign out_o.busy_res           = pos_q != '0;
  assign out_o.crc_error_count    = cnt_crc_q;
  assign out_o.length_error_count = cnt_len_q;

  `SFD_ASSERT(a_stall_blocks_input, clk_i, rst_ni, (ovalid_q && !out_o.ready) |-> !in_i.ready, "input taken while result stalled")
  `SFD_ASSERT(a_good_ends_frame, clk_i, rst_ni, (ovalid_q && status_q == ST_GOOD) |-> (pos_q == '0 && gv_q), "good frame left parser busy")
  `SFD_ASSERT(a_hit_needs_frame, clk_i, rst_ni, hit_q |-> (gv_q && status_q == ST_READ), "payload read without a good frame")
  `SFD_ASSERT(a_len_cnt_step, clk_i, rst_ni, (cnt_len_q != $past(cnt_len_q)) |-> (status_q == ST_BAD_LEN || $past(acc_clear)), "length counter moved without a bad length")
  `SFD_ASSERT_ALWAYS(a_no_ram_conflict, clk_i, !(ram_we && ram_re), "payload ram written and read together")

endmodule
